// ===== src/serial_frame_receiver_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame receiver
// Clocked property checks, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check with reset masking
`define SFRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check that also holds through reset
`define SFRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SFRC_ASSERT(lbl, prop, msg)
`define SFRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int unsigned BUF_DEPTH = 256;
    localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [7:0] HEADER_BYTE  = 8'h23;
    localparam logic [7:0] TRAILER_BYTE = 8'h24;

    typedef enum logic [1:0] {
        REQ_BYTE    = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_READ    = 2'd2
    } t_req_kind;

    typedef enum logic [5:0] {
        ST_HUNT = 6'b000001,
        ST_LEN  = 6'b000010,
        ST_PAY  = 6'b000100,
        ST_TRL  = 6'b001000,
        ST_CHK  = 6'b010000,
        ST_HELD = 6'b100000
    } t_parse_state;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    typedef struct packed {
        logic ready;
        logic complete;
    } t_frame_status;

endpackage

`default_nettype wire

// ===== src/serial_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_core
// Length-prefixed frame receiver with additive checksum and 256-byte buffer.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle and returns exactly one result beat per
// request, in the cycle after acceptance, through a single output register; the
// input stays ready while that register is empty or being drained. A byte
// request advances the frame parser and writes length or payload into a
// 256 x 8 single-port buffer; a read request reads that buffer, its
// registered read port being the output data register. Buffer contents are
// not cleared by reset and are meaningful only once written by a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] read_data
    output logic [1:0]       o_m_tuser    // [0] frame_ready, [1] frame_complete
);
    import sfr_pkg::*;

    logic              w_accept;
    logic [7:0]        w_rx_byte;
    logic [BUF_AW-1:0] w_read_index;
    t_store_wr         w_wr;
    t_frame_status     w_status;

    logic [7:0]        r_store [BUF_DEPTH];
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              r_out_ready;
    logic              r_out_complete;

    assign w_rx_byte    = i_s_tdata[7:0];
    assign w_read_index = i_s_tdata[8 +: BUF_AW];
    assign o_s_tready   = !r_out_valid || i_m_tready;
    assign w_accept     = i_s_tvalid && o_s_tready;

    sfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_s_tuser),
        .i_byte   (w_rx_byte),
        .o_wr     (w_wr),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr.en) begin
            r_store[w_wr.addr] <= w_wr.data;
        end
        if (w_accept) begin
            r_out_ready    <= w_status.ready;
            r_out_complete <= w_status.complete;
            if (i_s_tuser == REQ_READ) begin
                r_out_data <= r_store[w_read_index];
            end else begin
                r_out_data <= 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_complete, r_out_ready};

`include "serial_frame_receiver_core_assert.svh"

    `SFRC_ASSERT(a_out_complete_ready, r_out_valid && r_out_complete |-> r_out_ready, "complete beat without ready flag")
    `SFRC_ASSERT(a_beat_yields_result, w_accept |=> r_out_valid, "accepted beat produced no result")
    `SFRC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_out_valid, "result pending after reset")

endmodule

`default_nettype wire

// ===== src/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// sfr_parser
// Frame parser: header, length, payload, trailer and checksum tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [1:0]            i_req,
    input  wire logic [7:0]            i_byte,
    output sfr_pkg::t_store_wr         o_wr,
    output sfr_pkg::t_frame_status     o_status
);
    import sfr_pkg::*;

    t_parse_state      r_step, n_step;
    logic [7:0]        r_count, n_count;
    logic [7:0]        r_sum, n_sum;
    logic              r_ready, n_ready;
    logic [7:0]        r_len, n_len;
    logic [7:0]        w_sum_add;
    logic [7:0]        w_count_inc;
    logic              w_complete;

    assign w_sum_add   = r_sum + i_byte;
    assign w_count_inc = r_count + 8'd1;

    always_comb begin
        n_step     = r_step;
        n_count    = r_count;
        n_sum      = r_sum;
        n_ready    = r_ready;
        n_len      = r_len;
        w_complete = 1'b0;
        o_wr.en    = 1'b0;
        o_wr.addr  = '0;
        o_wr.data  = i_byte;
        unique case (i_req)
            REQ_BYTE: begin
                n_sum = w_sum_add;
                unique case (r_step)
                    ST_HUNT: begin
                        n_sum  = i_byte;
                        n_step = (i_byte == HEADER_BYTE) ? ST_LEN : ST_HUNT;
                    end
                    ST_LEN: begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = '0;
                        n_len     = i_byte;
                        n_count   = '0;
                        n_step    = ST_PAY;
                    end
                    ST_PAY: begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = w_count_inc[BUF_AW-1:0];
                        n_count   = w_count_inc;
                        if (w_count_inc >= r_len) begin
                            n_step = ST_TRL;
                        end
                    end
                    ST_TRL: begin
                        if (i_byte != TRAILER_BYTE) begin
                            n_sum  = i_byte;
                            n_step = (i_byte == HEADER_BYTE) ? ST_LEN : ST_HUNT;
                        end else begin
                            n_step = ST_CHK;
                        end
                    end
                    ST_CHK: begin
                        if (w_sum_add != 8'd0) begin
                            n_sum  = i_byte;
                            n_step = (i_byte == HEADER_BYTE) ? ST_LEN : ST_HUNT;
                        end else begin
                            n_ready    = 1'b1;
                            n_step     = ST_HELD;
                            w_complete = 1'b1;
                        end
                    end
                    ST_HELD: begin
                        n_sum = r_sum;
                    end
                    default: begin
                        n_sum = r_sum;
                    end
                endcase
            end
            REQ_RELEASE: begin
                n_step  = ST_HUNT;
                n_count = '0;
                n_sum   = '0;
                n_ready = 1'b0;
            end
            default: begin
            end
        endcase
        o_wr.en           = o_wr.en & i_accept;
        o_status.ready    = n_ready;
        o_status.complete = w_complete;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_HUNT;
            r_count <= '0;
            r_sum   <= '0;
            r_ready <= 1'b0;
        end else if (i_accept) begin
            r_step  <= n_step;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_ready <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_len <= n_len;
        end
    end

`include "serial_frame_receiver_core_assert.svh"

    `SFRC_ASSERT(a_ready_matches_held, r_ready == (r_step == ST_HELD), "ready flag without held frame")
    `SFRC_ASSERT(a_write_only_in_body, o_wr.en |-> (r_step == ST_LEN || r_step == ST_PAY), "buffer write outside length or payload")
    `SFRC_ASSERT(a_complete_holds, i_accept && o_status.complete |=> r_ready && r_step == ST_HELD, "completed frame not held")
    `SFRC_ASSERT(a_release_clears, i_accept && i_req == REQ_RELEASE |=> r_step == ST_HUNT && !r_ready && r_sum == 8'd0, "release left state behind")
    `SFRC_ASSERT(a_idle_holds, !i_accept |=> $stable(r_step) && $stable(r_count), "parser advanced without a beat")

endmodule

`default_nettype wire
